// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/dfd_pkg.sv -----
// Types and constants of the remote-control frame decoder.
// No dependencies; imported by dbus_frame_decoder, dfd_chain, dfd_decode and dfd_port_checker.
`timescale 1ns / 1ps

package dfd_pkg;

  localparam int FRAME_BYTES = 18;
  localparam int COUNT_W     = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 6'd63;
  localparam logic [COUNT_W-1:0] FRAME_COUNT = 6'(FRAME_BYTES);

  localparam logic [10:0] OFFSET_RESET    = 11'd1024;
  localparam logic [10:0] THRESHOLD_RESET = 11'd700;
  localparam logic [1:0]  DOWN_RESET      = 2'd2;
  localparam logic        CHECK_RESET     = 1'b1;

  localparam int NUM_STICKS = 4;
  localparam int TDATA_W    = 144;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_OFFSET    = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_DOWN_CODE = 2'd2,
    REG_CHECK_EN  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] channel_offset;
    logic [10:0] error_threshold;
    logic [1:0]  switch_down_code;
    logic        check_enable;
  } cfg_t;

  typedef struct packed {
    logic [10:0] stick_ch0;
    logic [10:0] stick_ch1;
    logic [10:0] stick_ch2;
    logic [10:0] stick_ch3;
    logic [15:0] wheel_ch4;
    logic [3:0]  switches;
    logic [15:0] mouse_x;
    logic [15:0] mouse_y;
    logic [15:0] mouse_z;
    logic [15:0] mouse_press;
    logic [15:0] key_bits;
    logic        data_error;
  } result_t;

endpackage

// ----- rtl/dbus_frame_decoder.sv -----
// The idle transaction that closes an 18-byte burst shows its result on m_tvalid in the
// next cycle; byte transactions give no result.
// Throughput: one input transaction per cycle; input waits only while a result is held by a
// low m_tready, and a new result enters the output register as the old one leaves.
// Reset (rst, synchronous): burst count cleared, output empty, registers to their defaults.
// Depends on dfd_pkg, dfd_chain and dfd_decode.
`timescale 1ns / 1ps

module dbus_frame_decoder import dfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input stream
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] rx_byte
  input  logic               s_tuser,   // [0] line_idle
  // Output stream
  output logic               m_tvalid,
  input  logic               m_tready,
  // [10:0] stick_ch0, [21:11] stick_ch1, [32:22] stick_ch2, [43:33] stick_ch3,
  // [59:44] wheel_ch4, [63:60] switches, [79:64] mouse_x, [95:80] mouse_y,
  // [111:96] mouse_z, [127:112] mouse_press, [143:128] key_bits
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tuser    // [0] data_error
);

  cfg_t                        cfg;
  logic                        cfg_write;
  reg_idx_t                    cfg_idx;
  logic [COUNT_W-1:0]          burst_count;
  logic [COUNT_W-1:0]          burst_count_next;
  logic                        in_acc;
  logic                        byte_acc;
  logic                        idle_acc;
  logic                        frame_hit;
  logic [FRAME_BYTES-1:0][7:0] frame;
  result_t                     dec_res;
  result_t                     res;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_offset   <= OFFSET_RESET;
      cfg.error_threshold  <= THRESHOLD_RESET;
      cfg.switch_down_code <= DOWN_RESET;
      cfg.check_enable     <= CHECK_RESET;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_OFFSET:    cfg.channel_offset   <= pwdata[10:0];
        REG_THRESHOLD: cfg.error_threshold  <= pwdata[10:0];
        REG_DOWN_CODE: cfg.switch_down_code <= pwdata[1:0];
        REG_CHECK_EN:  cfg.check_enable     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_OFFSET:    prdata = {21'd0, cfg.channel_offset};
      REG_THRESHOLD: prdata = {21'd0, cfg.error_threshold};
      REG_DOWN_CODE: prdata = {30'd0, cfg.switch_down_code};
      REG_CHECK_EN:  prdata = {31'd0, cfg.check_enable};
      default:       prdata = '0;
    endcase
  end

  // Input side.
  assign s_tready  = !m_tvalid || m_tready;
  assign in_acc    = s_tvalid && s_tready;
  assign byte_acc  = in_acc && !s_tuser;
  assign idle_acc  = in_acc && s_tuser;
  assign frame_hit = idle_acc && (burst_count == FRAME_COUNT);

  always_comb begin
    burst_count_next = burst_count;
    if (idle_acc) begin
      burst_count_next = '0;
    end else if (byte_acc && (burst_count != COUNT_MAX)) begin
      burst_count_next = burst_count + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_count <= '0;
    end else begin
      burst_count <= burst_count_next;
    end
  end

  // Bytes past the frame length still shift, but such a burst never decodes.
  dfd_chain u_chain (
    .clk      (clk),
    .shift_en (byte_acc),
    .rx_byte  (s_tdata),
    .frame    (frame)
  );

  dfd_decode u_decode (
    .frame (frame),
    .cfg   (cfg),
    .res   (dec_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (frame_hit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_hit) begin
      res <= dec_res;
    end
  end

  assign m_tdata = {res.key_bits, res.mouse_press, res.mouse_z, res.mouse_y, res.mouse_x,
                    res.switches, res.wheel_ch4, res.stick_ch3, res.stick_ch2,
                    res.stick_ch1, res.stick_ch0};
  assign m_tuser = res.data_error;

endmodule

// ----- rtl/dfd_cell.sv -----
// One byte cell of the frame shift chain.
// Standalone; instantiated by dfd_chain.
`timescale 1ns / 1ps

module dfd_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] din,
  output logic [7:0] dout
);

  logic [7:0] data;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data <= din;
    end
  end

  assign dout = data;

endmodule

// ----- rtl/dfd_chain.sv -----
// Row of byte cells that holds the bytes of the current burst.
// Depends on dfd_pkg and dfd_cell.
`timescale 1ns / 1ps

module dfd_chain import dfd_pkg::*; (
  input  logic                        clk,
  input  logic                        shift_en,
  input  logic [7:0]                  rx_byte,
  output logic [FRAME_BYTES-1:0][7:0] frame
);

  // A new byte enters the top cell and every cell passes its byte one place
  // down, so after a full frame cell 0 holds the first byte of the burst.
  for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
    logic [7:0] din;
    if (i == FRAME_BYTES - 1) begin : g_top
      assign din = rx_byte;
    end else begin : g_mid
      assign din = frame[i+1];
    end
    dfd_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .din      (din),
      .dout     (frame[i])
    );
  end

endmodule

// ----- rtl/dfd_decode.sv -----
// Field extraction, offset removal and validity check of one stored frame.
// Depends on dfd_pkg.
`timescale 1ns / 1ps

module dfd_decode import dfd_pkg::*; (
  input  logic [FRAME_BYTES-1:0][7:0] frame,
  input  cfg_t                        cfg,
  output result_t                     res
);

  logic [NUM_STICKS-1:0][10:0] raw;
  logic [NUM_STICKS-1:0][11:0] diff;
  logic [NUM_STICKS-1:0][11:0] mag;
  logic [NUM_STICKS-1:0][10:0] sat;
  logic [NUM_STICKS-1:0]       over;
  logic [1:0]                  sw_left;
  logic [1:0]                  sw_right;
  logic [15:0]                 wheel;
  logic                        err;

  assign raw[0] = {frame[1][2:0], frame[0]};
  assign raw[1] = {frame[2][5:0], frame[1][7:3]};
  assign raw[2] = {frame[4][0], frame[3], frame[2][7:6]};
  assign raw[3] = {frame[5][3:0], frame[4][7:1]};
  assign sw_left  = frame[5][5:4];
  assign sw_right = frame[5][7:6];
  assign wheel = {frame[17], frame[16]} - {5'd0, cfg.channel_offset};

  always_comb begin
    for (int i = 0; i < NUM_STICKS; i++) begin
      diff[i] = {1'b0, raw[i]} - {1'b0, cfg.channel_offset};
      mag[i]  = diff[i][11] ? (~diff[i] + 12'd1) : diff[i];
      over[i] = mag[i] > {1'b0, cfg.error_threshold};
      // The 12-bit difference fits 11 bits when its top two bits agree.
      if (diff[i][11] == diff[i][10]) begin
        sat[i] = diff[i][10:0];
      end else if (diff[i][11]) begin
        sat[i] = 11'h400;
      end else begin
        sat[i] = 11'h3FF;
      end
    end
  end

  assign err = cfg.check_enable &&
               ((|over) || (sw_left == 2'd0) || (sw_right == 2'd0));

  always_comb begin
    if (err) begin
      res            = '0;
      res.switches   = {cfg.switch_down_code, cfg.switch_down_code};
      res.data_error = 1'b1;
    end else begin
      res.stick_ch0   = sat[0];
      res.stick_ch1   = sat[1];
      res.stick_ch2   = sat[2];
      res.stick_ch3   = sat[3];
      res.wheel_ch4   = wheel;
      res.switches    = {sw_right, sw_left};
      res.mouse_x     = {frame[7], frame[6]};
      res.mouse_y     = {frame[9], frame[8]};
      res.mouse_z     = {frame[11], frame[10]};
      res.mouse_press = {frame[13], frame[12]};
      res.key_bits    = {frame[15], frame[14]};
      res.data_error  = 1'b0;
    end
  end

endmodule

// ----- rtl/dfd_checker.sv -----
// Port-level checks of the frame decoder, bound to the top level.
// Depends on dfd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfd_port_checker import dfd_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic [7:0]         s_tdata,
  input logic               s_tuser,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tuser
);

  logic byte_free;

  // A byte transaction taken while the output is not stalled.
  assign byte_free = s_tvalid && s_tready && !s_tuser && (s_tdata == s_tdata) &&
                     !(m_tvalid && !m_tready);

  `ASSERT_CLK_NORST(a_reset_empty, clk, rst |=> !m_tvalid, "output valid after reset")
  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
    "stalled result changed")
  `ASSERT_CLK(a_byte_no_result, clk, rst, byte_free |=> !m_tvalid,
    "byte transaction produced a result")
  `ASSERT_CLK(a_error_cleared, clk, rst,
    m_tvalid && m_tuser |-> (m_tdata[59:0] == 60'd0) && (m_tdata[143:64] == 80'd0) &&
    (m_tdata[61:60] == m_tdata[63:62]), "error result not cleared")
  `ASSERT_CLK(a_ready_when_empty, clk, rst, !m_tvalid |-> s_tready,
    "input stalled with empty output")

endmodule

bind dbus_frame_decoder dfd_port_checker u_dfd_checker (.*);
